// ===== design/rhsv_pkg.sv =====
package rhsv_pkg;

    // Default and limits of the CORDIC chain
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int DIV_STEPS         = 17;

    // Fixed-point formats
    localparam int XY_W  = 26;
    localparam int Z_W   = 24;
    localparam int Q_W   = 17;
    localparam int HUE_W = 15;

    localparam logic [14:0]        SQRT3_Q14 = 15'd28378;
    localparam logic signed [Z_W-1:0] DEG90  = 24'sd1474560;
    localparam logic signed [Z_W-1:0] DEG180 = 24'sd2949120;
    localparam logic [Z_W-1:0]        DEG360 = 24'd5898240;
    localparam logic [15:0]           HUE_FULL = 16'd23040;

    // Data carried from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [7:0]             rem;
        logic [Q_W-1:0]         num_lo;
        logic [Q_W-1:0]         quo;
        logic [7:0]             dvs;
        logic [Q_W-1:0]         val;
        logic                   b_gt_g;
        logic                   gray;
    } cell_data_t;

    // atan(2^-i) in degrees, scaled by 2^14
    function automatic logic [19:0] atan_entry(input int i);
        logic [19:0] v;
        case (i)
            0:  v = 20'd737280;
            1:  v = 20'd435242;
            2:  v = 20'd229970;
            3:  v = 20'd116736;
            4:  v = 20'd58595;
            5:  v = 20'd29326;
            6:  v = 20'd14667;
            7:  v = 20'd7334;
            8:  v = 20'd3667;
            9:  v = 20'd1833;
            10: v = 20'd917;
            11: v = 20'd458;
            12: v = 20'd229;
            13: v = 20'd115;
            14: v = 20'd57;
            15: v = 20'd29;
            16: v = 20'd14;
            17: v = 20'd7;
            18: v = 20'd4;
            19: v = 20'd2;
            20: v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/rgb_to_hue_sat_val.sv =====
// RGB to hue/saturation/value converter, one pixel per transaction.
// Input stream: s_axis_tdata carries red, green, blue (8 bits each).
// Output stream: m_axis_tdata carries hue (1/64 degree), saturation and
// value (both Q1.16); m_axis_tuser is set when the pixel is gray and the
// hue is forced to 0.
// Throughput: one pixel per clock when the receiver keeps tready high.
// Each pixel passes the front-end register, CHAIN cell registers and the
// output register; CHAIN is the larger of CORDIC_STAGES (capped at 24)
// and the 17 steps of the saturation divider. The data path is a chain
// of cells: each of the first CORDIC_STAGES (capped at 24) does one
// CORDIC rotation for the hue angle, each of the first 17 one quotient
// bit of saturation. Every stage holds its own valid bit; a stall holds
// each full stage while empty ones still fill, so bubbles are squeezed
// out, no transaction is lost. Reset clears valid bits, not pipeline data.
module rgb_to_hue_sat_val #(
    parameter int CORDIC_STAGES = rhsv_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // hue_out, sat_out, val_out, zero pad
    output logic [0:0]  m_axis_tuser   // hue_undefined
);

    localparam int STAGES_EFF = (CORDIC_STAGES > rhsv_pkg::TABLE_LEN) ?
                                rhsv_pkg::TABLE_LEN : CORDIC_STAGES;
    localparam int CHAIN = (STAGES_EFF > rhsv_pkg::DIV_STEPS) ?
                           STAGES_EFF : rhsv_pkg::DIV_STEPS;

    logic                 valid_c [CHAIN+1];
    logic                 ready_c [CHAIN+1];
    rhsv_pkg::cell_data_t data_c  [CHAIN+1];

    logic [14:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
    logic        undef;

    // Front end: max/min, start vector, dividend
    rhsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red_in    (s_axis_tdata[7:0]),
        .green_in  (s_axis_tdata[15:8]),
        .blue_in   (s_axis_tdata[23:16]),
        .out_valid (valid_c[0]),
        .out_ready (ready_c[0]),
        .out_data  (data_c[0])
    );

    // Cell chain
    for (genvar i = 0; i < CHAIN; i++)
    begin : g_cell
        rhsv_cell #(
            .IDX       (i),
            .CORDIC_ON (i < STAGES_EFF),
            .DIV_ON    (i < rhsv_pkg::DIV_STEPS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_data   (data_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_data  (data_c[i+1])
        );
    end

    // Back end and output register
    rhsv_post u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (valid_c[CHAIN]),
        .in_ready      (ready_c[CHAIN]),
        .in_data       (data_c[CHAIN]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .hue_out       (hue),
        .sat_out       (sat),
        .val_out       (val),
        .hue_undefined (undef)
    );

    assign m_axis_tdata = {7'd0, val, sat, hue};
    assign m_axis_tuser = undef;

endmodule

// ===== design/rhsv_prep.sv =====
module rhsv_prep (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             red_in,
    input  logic [7:0]             green_in,
    input  logic [7:0]             blue_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output rhsv_pkg::cell_data_t   out_data
);

    logic                 valid_reg;
    rhsv_pkg::cell_data_t data_reg;
    rhsv_pkg::cell_data_t data_next;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  diff_gb;
    logic signed [10:0] dx;
    logic signed [rhsv_pkg::XY_W-1:0] x0;
    logic signed [rhsv_pkg::XY_W-1:0] y0;
    logic [22:0] y_prod;
    logic [23:0] num;

    assign in_ready = !valid_reg || out_ready;

    // Max/min, start vector, dividend
    always_comb
    begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        diff_gb = (green_in > blue_in) ? green_in - blue_in : blue_in - green_in;
        dx = $signed({2'b00, red_in, 1'b0}) - $signed({3'b000, green_in})
             - $signed({3'b000, blue_in});
        x0 = {{(rhsv_pkg::XY_W-25){dx[10]}}, dx, 14'd0};
        y_prod = diff_gb * rhsv_pkg::SQRT3_Q14;
        y0 = $signed({{(rhsv_pkg::XY_W-23){1'b0}}, y_prod});
        num = {mx - mn, 16'd0} + {17'd0, mx[7:1]};

        data_next.rem    = {1'b0, num[23:17]};
        data_next.num_lo = num[16:0];
        data_next.quo    = '0;
        data_next.dvs    = mx;
        data_next.val    = ({9'd0, mx} << 8) + {9'd0, mx} + {16'd0, mx[7]};
        data_next.b_gt_g = blue_in > green_in;
        data_next.gray   = (red_in == green_in) && (green_in == blue_in);
        // left half-plane: pre-rotate by -90 degrees
        if (x0 < 0)
        begin
            data_next.x = y0;
            data_next.y = -x0;
            data_next.z = rhsv_pkg::DEG90;
        end
        else
        begin
            data_next.x = x0;
            data_next.y = y0;
            data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/rhsv_cell.sv =====
module rhsv_cell #(
    parameter int IDX       = 0,
    parameter bit CORDIC_ON = 1'b1,
    parameter bit DIV_ON    = 1'b1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rhsv_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rhsv_pkg::cell_data_t out_data
);

    localparam logic signed [rhsv_pkg::Z_W-1:0] ATAN =
        $signed({4'd0, rhsv_pkg::atan_entry(IDX)});

    logic                 valid_reg;
    rhsv_pkg::cell_data_t data_reg;
    rhsv_pkg::cell_data_t data_next;

    logic signed [rhsv_pkg::XY_W-1:0] xs;
    logic signed [rhsv_pkg::XY_W-1:0] ys;
    logic [8:0] trial;
    logic       ge;

    assign in_ready = !valid_reg || out_ready;

    // One CORDIC rotation (if CORDIC_ON) and one restoring division step (if DIV_ON)
    always_comb
    begin
        data_next = in_data;
        xs = in_data.x >>> IDX;
        ys = in_data.y >>> IDX;
        trial = {in_data.rem, in_data.num_lo[rhsv_pkg::Q_W-1]};
        ge = trial >= {1'b0, in_data.dvs};
        if (CORDIC_ON)
        begin
            if (in_data.y >= 0)
            begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + ATAN;
            end
            else
            begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - ATAN;
            end
        end
        if (DIV_ON)
        begin
            data_next.rem    = ge ? 8'(trial - {1'b0, in_data.dvs}) : trial[7:0];
            data_next.num_lo = in_data.num_lo << 1;
            data_next.quo    = {in_data.quo[rhsv_pkg::Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/rhsv_post.sv =====
module rhsv_post (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rhsv_pkg::cell_data_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [14:0]          hue_out,
    output logic [16:0]          sat_out,
    output logic [16:0]          val_out,
    output logic                 hue_undefined
);

    logic        valid_reg;
    logic [14:0] hue_reg;
    logic [16:0] sat_reg;
    logic [16:0] val_reg;
    logic        undef_reg;

    logic [14:0] hue_next;
    logic [16:0] sat_next;
    logic [23:0] zc;
    logic [23:0] h;
    logic [15:0] hr;

    assign in_ready = !valid_reg || out_ready;

    // Clamp angle, reflect, round to 1/64 degree, wrap full circle; zero hue if gray, saturation if black
    always_comb
    begin
        if (in_data.z < 0)
            zc = '0;
        else if (in_data.z > rhsv_pkg::DEG180)
            zc = rhsv_pkg::DEG180;
        else
            zc = in_data.z;
        h  = in_data.b_gt_g ? rhsv_pkg::DEG360 - zc : zc;
        hr = 16'((h + 24'd128) >> 8);
        if (in_data.gray || hr >= rhsv_pkg::HUE_FULL)
            hue_next = '0;
        else
            hue_next = hr[14:0];
        sat_next = (in_data.dvs == 8'd0) ? '0 : in_data.quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            val_reg   <= in_data.val;
            undef_reg <= in_data.gray;
        end
    end

    assign out_valid     = valid_reg;
    assign hue_out       = hue_reg;
    assign sat_out       = sat_reg;
    assign val_out       = val_reg;
    assign hue_undefined = undef_reg;

endmodule

// ===== design/rhsv_checker.sv =====
module rhsv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Stalled output transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // Hue stays below a full circle
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:0] < 15'd23040)
        else $error("hue out of range");

    // Gray pixel reports zero hue and zero saturation
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[14:0] == 15'd0 && m_axis_tdata[31:15] == 17'd0)
        else $error("gray pixel with nonzero hue or saturation");

    // Saturation and value do not exceed one; pad bits stay zero
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:15] <= 17'd65536 &&
            m_axis_tdata[48:32] <= 17'd65536 && m_axis_tdata[55:49] == 7'd0)
        else $error("saturation or value out of range");

endmodule

bind rgb_to_hue_sat_val rhsv_checker u_rhsv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
